// ----- rtl/afr_pkg.sv -----
`timescale 1ns / 1ps

package afr_pkg;

  localparam int MAX_DATA_DEF = 32;
  localparam int PADDR_W = 3;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] LEN_HI_OK = 8'h00;
  localparam logic [7:0] CSUM_BASE = 8'hFF;
  localparam logic [7:0] TIMEOUT_RESET = 8'd10;

  // register index, taken from paddr[2]
  localparam logic REG_TIMEOUT = 1'b0;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_CSUM_ERR = 1'b1;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
    logic       status;
    logic [5:0] frame_length;
  } res_t;

  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_LEN_HI = 6'b000010,
    PH_LEN_LO = 6'b000100,
    PH_DATA   = 6'b001000,
    PH_CSUM   = 6'b010000,
    PH_READ   = 6'b100000
  } phase_t;

endpackage

// ----- rtl/api_frame_receiver.sv -----
`timescale 1ns / 1ps

// channel   | handshake              | payload
// ----------+------------------------+-----------------------------------
// request   | req_valid / req_ready  | req : func, rx_byte
// result    | res_valid / res_ready  | res : data, is_last, status, frame_length
// config    | apb psel/penable/...   | timeout_ticks at byte address 0
//
// every byte or tick request is handled as soon as it is taken; a good frame
// of n bytes is read back out of the frame store at one byte per cycle while
// results are taken, through the single registered read port
// requests wait during that readout; a checksum byte waits while a result
// still sits in the output register; a stalled result just holds the readout
// rst is synchronous: hunting, timer stopped, frame store left unreset

module api_frame_receiver #(
  parameter int MAX_DATA = afr_pkg::MAX_DATA_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  afr_pkg::req_t             req,
  output logic                      res_valid,
  input  logic                      res_ready,
  output afr_pkg::res_t             res,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [afr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  import afr_pkg::*;

  localparam int LEN_W = $clog2(MAX_DATA + 1);
  localparam int ADDR_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

  // config register
  logic [7:0] timeout_ticks;

  // frame control
  phase_t     phase, phase_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [LEN_W-1:0] data_length, data_length_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] tick_count, tick_count_next;

  // frame store and its read side
  logic [7:0] frame_store [MAX_DATA];
  logic [7:0] store_q;
  logic [LEN_W-1:0] rd_addr, rd_addr_next;
  logic       rd_en;
  logic       rd_pending;
  logic       rd_last;
  logic       rd_move;

  logic       wr_en;
  logic       req_fire;
  logic       err_load;
  logic [7:0] tick_inc;
  logic [LEN_W-1:0] count_inc;

  // output register
  res_t       res_q;
  logic       res_vq;

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? {24'b0, timeout_ticks} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
      timeout_ticks <= pwdata[7:0];
    end
  end

  // a checksum byte may produce a result right away, so it needs a free slot
  assign req_ready = (phase != PH_READ) && !rd_pending &&
                     ((phase != PH_CSUM) || !res_vq || res_ready);
  assign req_fire = req_valid && req_ready;

  // read data moves to the output register when the slot frees up
  assign rd_move = rd_pending && (!res_vq || res_ready);
  assign rd_en = (phase == PH_READ) && (!rd_pending || rd_move);

  assign tick_inc = tick_count + 8'd1;
  assign count_inc = byte_count + LEN_W'(1);

  always_comb begin
    phase_next = phase;
    byte_count_next = byte_count;
    data_length_next = data_length;
    running_sum_next = running_sum;
    tick_count_next = tick_count;
    rd_addr_next = rd_addr;
    wr_en = 1'b0;
    err_load = 1'b0;

    if (phase == PH_READ) begin
      if (rd_en) begin
        rd_addr_next = rd_addr + LEN_W'(1);
        if (rd_addr == data_length - LEN_W'(1)) begin
          phase_next = PH_HUNT;
        end
      end
    end else if (req_fire && req.func == FUNC_TICK) begin
      // timer runs only inside a frame
      if (phase != PH_HUNT) begin
        tick_count_next = tick_inc;
        if (tick_inc >= timeout_ticks) begin
          phase_next = PH_HUNT;
          tick_count_next = 8'd0;
        end
      end
    end else if (req_fire) begin
      tick_count_next = 8'd0;
      case (phase)
        PH_HUNT: begin
          if (req.rx_byte == START_BYTE) begin
            phase_next = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          phase_next = (req.rx_byte == LEN_HI_OK) ? PH_LEN_LO : PH_HUNT;
        end
        PH_LEN_LO: begin
          if (req.rx_byte == 8'd0 || req.rx_byte > 8'(MAX_DATA)) begin
            phase_next = PH_HUNT;
          end else begin
            data_length_next = LEN_W'(req.rx_byte);
            byte_count_next = '0;
            running_sum_next = 8'd0;
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          wr_en = 1'b1;
          running_sum_next = running_sum + req.rx_byte;
          byte_count_next = count_inc;
          if (count_inc >= data_length) begin
            phase_next = PH_CSUM;
          end
        end
        PH_CSUM: begin
          if (CSUM_BASE - running_sum == req.rx_byte) begin
            rd_addr_next = '0;
            phase_next = PH_READ;
          end else begin
            err_load = 1'b1;
            phase_next = PH_HUNT;
          end
        end
        default: begin
          // unused codes fall back to hunting
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      byte_count <= '0;
      data_length <= '0;
      running_sum <= 8'd0;
      tick_count <= 8'd0;
      rd_addr <= '0;
    end else begin
      phase <= phase_next;
      byte_count <= byte_count_next;
      data_length <= data_length_next;
      running_sum <= running_sum_next;
      tick_count <= tick_count_next;
      rd_addr <= rd_addr_next;
    end
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_store[byte_count[ADDR_W-1:0]] <= req.rx_byte;
    end
    if (rd_en) begin
      store_q <= frame_store[rd_addr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      rd_last <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_pending <= 1'b1;
        rd_last <= (rd_addr == data_length - LEN_W'(1));
      end else if (rd_move) begin
        rd_pending <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vq <= 1'b0;
    end else if (rd_move || err_load) begin
      res_vq <= 1'b1;
    end else if (res_ready) begin
      res_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_move) begin
      res_q.data <= store_q;
      res_q.is_last <= rd_last;
      res_q.status <= STATUS_OK;
      res_q.frame_length <= 6'(data_length);
    end else if (err_load) begin
      res_q.data <= 8'd0;
      res_q.is_last <= 1'b1;
      res_q.status <= STATUS_CSUM_ERR;
      res_q.frame_length <= 6'(data_length);
    end
  end

  assign res_valid = res_vq;
  assign res = res_q;

`ifndef SYNTHESIS
  // no new request while the store is being read out
  a_no_req_in_readout: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_READ || rd_pending) |-> !req_ready)
    else $error("request taken during readout");

  // pending read data is never overwritten before it moves out
  a_no_read_overrun: assert property (@(posedge clk) disable iff (rst)
    (rd_pending && res_vq && !res_ready) |-> !rd_en)
    else $error("read data overwritten");

  // a checksum byte ends the frame one way or the other
  a_csum_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.func == FUNC_BYTE && phase == PH_CSUM) |=>
      (phase == PH_HUNT || phase == PH_READ))
    else $error("checksum byte left frame open");

  // timer is stopped while hunting
  a_timer_stopped: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT) |-> (tick_count == 8'd0))
    else $error("timer running while hunting");

  // an error result is always a run of one
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == STATUS_CSUM_ERR) |-> res.is_last)
    else $error("error result without last mark");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

// frame receiver testbench
// bytes and timer ticks go in as requests over valid/ready, frame bytes and
// checksum errors come back over valid/ready. a cycle-free predictor tracks
// the header hunt, the data sum and the tick timer, and queues the results a
// request should cause. a checker pops that queue on every accepted result.
// directed tests first, then random frame traffic under four idle/stall mixes

module tb_top;
  import afr_pkg::*;

  logic clk = 1'b0;
  logic rst;

  logic req_valid;
  logic req_ready;
  req_t req;
  logic res_valid;
  logic res_ready;
  res_t res;

  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // predictor state
  phase_t rx_phase;
  logic [5:0] rx_len;
  logic [5:0] rx_cnt;
  logic [7:0] rx_sum;
  logic [7:0] rx_ticks;
  logic [7:0] rx_store [0:MAX_DATA_DEF-1];
  logic [7:0] tmo_ticks;

  // frame bytes and error results still owed by the block
  res_t frame_out_q [$];

  int errors = 0;
  int items_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  api_frame_receiver dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver side stalls at random, changing at the falling edge
  always @(negedge clk) begin
    res_ready <= ($urandom_range(99) >= stall_pct);
  end

  // one request through the frame parser, queuing whatever results it causes
  function automatic void track_frame(input req_t r);
    if (r.func == FUNC_TICK) begin
      // timer only runs while a frame is open
      if (rx_phase != PH_HUNT) begin
        rx_ticks = rx_ticks + 8'd1;
        if (rx_ticks >= tmo_ticks) begin
          rx_phase = PH_HUNT;
          rx_ticks = 8'd0;
        end
      end
      return;
    end
    // any byte restarts the timer
    rx_ticks = 8'd0;
    case (rx_phase)
      PH_LEN_HI: begin
        rx_phase = (r.rx_byte == LEN_HI_OK) ? PH_LEN_LO : PH_HUNT;
      end
      PH_LEN_LO: begin
        // zero or oversize length drops the frame silently
        if (r.rx_byte == 8'd0 || r.rx_byte > MAX_DATA_DEF) begin
          rx_phase = PH_HUNT;
        end else begin
          rx_len = r.rx_byte[5:0];
          rx_cnt = 6'd0;
          rx_sum = 8'd0;
          rx_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        rx_store[rx_cnt[4:0]] = r.rx_byte;
        rx_sum = rx_sum + r.rx_byte;
        rx_cnt = rx_cnt + 6'd1;
        if (rx_cnt >= rx_len) rx_phase = PH_CSUM;
      end
      PH_CSUM: begin
        if (CSUM_BASE - rx_sum == r.rx_byte) begin
          for (int i = 0; i < rx_len; i++) begin
            frame_out_q.push_back('{data: rx_store[5'(i)], is_last: (i + 1 == rx_len),
                                    status: STATUS_OK, frame_length: rx_len});
          end
        end else begin
          frame_out_q.push_back('{data: 8'd0, is_last: 1'b1,
                                  status: STATUS_CSUM_ERR, frame_length: rx_len});
        end
        rx_phase = PH_HUNT;
      end
      default: begin
        // hunting, also covers any stray phase value
        rx_phase = (r.rx_byte == START_BYTE) ? PH_LEN_HI : PH_HUNT;
      end
    endcase
  endfunction

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (frame_out_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual data=%h last=%b status=%b len=%0d",
                 $time, res.data, res.is_last, res.status, res.frame_length);
        errors++;
      end else begin
        want = frame_out_q.pop_front();
        if (res.data !== want.data || res.is_last !== want.is_last ||
            res.status !== want.status || res.frame_length !== want.frame_length) begin
          $display({"%0t: result mismatch expected data=%h last=%b status=%b len=%0d",
                    " actual data=%h last=%b status=%b len=%0d"},
                   $time, want.data, want.is_last, want.status, want.frame_length,
                   res.data, res.is_last, res.status, res.frame_length);
          errors++;
        end
      end
    end
  end

  // one request: random idle gap, then hold valid until taken
  task automatic send_req(input logic func, input logic [7:0] b);
    req_t r;
    r.func = func;
    r.rx_byte = b;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    track_frame(r);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_req(FUNC_BYTE, b);
  endtask

  // payload of a tick is don't-care, so keep it random
  task automatic send_tick();
    send_req(FUNC_TICK, 8'($urandom_range(255)));
  endtask

  // stop sending and let every owed result come back
  task automatic wait_idle();
    int n;
    @(negedge clk);
    req_valid <= 1'b0;
    for (n = 0; n < 20000 && frame_out_q.size() != 0; n++) @(posedge clk);
    // tail for requests that cause no result
    repeat (40) @(posedge clk);
  endtask

  // apb write of the timeout register, then read it back
  task automatic write_timeout(input logic [7:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_TIMEOUT, 2'b00};
    pwdata <= {24'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tmo_ticks = val;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== val) begin
      $display("%0t: timeout readback expected %h actual %h", $time, val, prdata[7:0]);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // good frame carrying 00, start byte and ff as data
  task automatic test_good_frames();
    send_byte(START_BYTE);
    send_byte(LEN_HI_OK);
    send_byte(8'd3);
    send_byte(8'h00);
    send_byte(START_BYTE);
    send_byte(8'hFF);
    send_byte(CSUM_BASE - (START_BYTE + 8'hFF));
  endtask

  // nonzero length high byte, zero length, length one past the store
  task automatic test_bad_headers();
    send_byte(START_BYTE);
    send_byte(8'h01);
    send_byte(START_BYTE);
    send_byte(LEN_HI_OK);
    send_byte(8'd0);
    send_byte(START_BYTE);
    send_byte(LEN_HI_OK);
    send_byte(8'(MAX_DATA_DEF + 1));
  endtask

  task automatic test_checksum_error();
    send_byte(START_BYTE);
    send_byte(LEN_HI_OK);
    send_byte(8'd1);
    send_byte(8'h55);
    send_byte(8'h00);
  endtask

  // tick while hunting, then shortest timeout and a zero register
  task automatic test_ticks_and_timeout();
    send_tick();
    wait_idle();
    write_timeout(8'd1);
    send_byte(START_BYTE);
    send_tick();
    // frame was dropped, so this is just noise while hunting
    send_byte(LEN_HI_OK);
    wait_idle();
    write_timeout(8'd0);
    send_byte(START_BYTE);
    send_tick();
  endtask

  // one random frame, mostly well formed, sometimes noisy or broken
  task automatic send_rand_frame(input int force_len);
    int kind;
    int len;
    int cut;
    int tmo;
    logic [7:0] sum;
    logic [7:0] b;
    kind = (force_len != 0) ? 99 : $urandom_range(99);
    if (force_len != 0) len = force_len;
    else if ($urandom_range(9) == 0) len = $urandom_range(MAX_DATA_DEF, 7);
    else len = $urandom_range(6, 1);
    tmo = (tmo_ticks == 8'd0) ? 1 : tmo_ticks;
    // only let a frame time out when that costs few ticks
    cut = (kind >= 20 && kind < 28 && tmo <= 20) ? $urandom_range(len - 1) : -1;
    sum = 8'd0;
    // line noise ahead of the frame
    if (kind < 8) repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
    send_byte(START_BYTE);
    if (kind >= 8 && kind < 14) begin
      send_byte(8'($urandom_range(255, 1)));
      return;
    end
    send_byte(LEN_HI_OK);
    if (kind >= 14 && kind < 20) begin
      send_byte($urandom_range(1) ? 8'd0 : 8'($urandom_range(255, MAX_DATA_DEF + 1)));
      return;
    end
    send_byte(8'(len));
    for (int i = 0; i < len; i++) begin
      if (i == cut) begin
        repeat (tmo) send_tick();
        return;
      end
      // a few ticks that stay under the timeout
      if ($urandom_range(7) == 0 && tmo > 1) begin
        repeat ($urandom_range((tmo - 1 > 4) ? 4 : tmo - 1, 1)) send_tick();
      end
      b = 8'($urandom_range(255));
      sum = sum + b;
      send_byte(b);
    end
    if (kind >= 28 && kind < 40) send_byte((CSUM_BASE - sum) ^ 8'($urandom_range(255, 1)));
    else send_byte(CSUM_BASE - sum);
  endtask

  // one traffic phase: drain, retune the timer, then frames until the item budget
  task automatic test_random_traffic(input int idle, input int stall,
                                     input logic [7:0] tmo, input int budget,
                                     input int first_len);
    int stop_at;
    wait_idle();
    write_timeout(tmo);
    idle_pct = idle;
    stall_pct = stall;
    stop_at = items_sent + budget;
    if (first_len != 0) send_rand_frame(first_len);
    while (items_sent < stop_at) send_rand_frame(0);
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'd0;
    rx_phase = PH_HUNT;
    rx_len = 6'd0;
    rx_cnt = 6'd0;
    rx_sum = 8'd0;
    rx_ticks = 8'd0;
    tmo_ticks = TIMEOUT_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_good_frames();
    test_bad_headers();
    test_checksum_error();
    test_ticks_and_timeout();

    // no idling, widest timeout, and one frame of the largest size
    test_random_traffic(0, 0, 8'd255, 40, MAX_DATA_DEF);
    test_random_traffic(76, 0, 8'($urandom_range(20, 2)), 35, 0);
    test_random_traffic(0, 76, 8'd1, 35, 0);
    test_random_traffic(31, 31, TIMEOUT_RESET, 35, 0);

    wait_idle();
    if (frame_out_q.size() != 0) begin
      $display("%0t: %0d expected results never came", $time, frame_out_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
